@@ rtl/core/bai_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bai_pkg : shared types for the bounded insert/erase list
// Capacity, entry width, command and status codes, cell control word.
// ----------------------------------------------------------------------------
package bai_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int POS_W  = 6;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // compare width: holds both a count and any position value
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    localparam int IN_W  = 48;  // 3 + 6 + 32 = 41, padded to bytes
    localparam int OUT_W = 48;  // 32 + 7 + 1 + 2 = 42, padded to bytes

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_APPEND = 2'd1,
        OP_INSERT = 2'd2,
        OP_ERASE  = 2'd3
    } cell_op_t;

    typedef logic [DATA_WIDTH-1:0] entry_t;

    typedef struct packed {
        cell_op_t         op;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] cnt;
        entry_t           data;
    } cell_ctl_t;

    // low DATA_WIDTH bits of the word, zero above bit 31
    function automatic entry_t to_entry(input logic [WORD_W-1:0] w);
        entry_t e;
        e = '0;
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            if (b < WORD_W)
                e[b] = w[b];
        end
        return e;
    endfunction

    // sign-extend from DATA_WIDTH, keep low 32 bits
    function automatic logic [WORD_W-1:0] from_entry(input entry_t e);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (b < DATA_WIDTH)
                w[b] = e[b];
            else
                w[b] = e[DATA_WIDTH-1];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/bounded_array_insert_erase.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_insert_erase : ordered list with shifting insert and erase
// Row of storage cells; commands shift, load or read entries or change the count.
// ----------------------------------------------------------------------------
// Result word: registered, valid in the cycle after the command is taken.
// Throughput: one command per cycle unless stalled; cells shift in parallel.
// Output register: a new command is taken while the result is being read.
// Reset: count cleared to zero, output empty; entry contents are not reset.
module bounded_array_insert_erase (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // [2:0] command, [8:3] position, [40:9] data_in, [47:41] zero
    input  wire  [bai_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // [31:0] read_data, [38:32] entry_count, [39] is_empty, [41:40] status,
    // [47:42] zero
    output logic [bai_pkg::OUT_W-1:0]   m_tdata
);
    import bai_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    logic              accept;
    cmd_t              command;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic              full;
    cell_op_t          op;
    status_t           status;
    logic [WORD_W-1:0] read_data;
    cell_ctl_t         ctl;
    entry_t            rd_sel;

    entry_t            cell_data [CAPACITY];
    entry_t            cell_rd   [CAPACITY];

    assign command  = cmd_t'(s_tdata[2:0]);
    assign position = s_tdata[8:3];
    assign data_in  = s_tdata[40:9];

    assign pos_c = CMP_W'(position);
    assign cnt_c = CMP_W'(count_reg);
    assign full  = (cnt_c >= CMP_W'(CAPACITY));

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_sel = rd_sel | cell_rd[i];
        end
    end

    always_comb
    begin
        op         = OP_HOLD;
        status     = ST_DONE;
        read_data  = '0;
        count_next = count_reg;
        unique case (command)
            CMD_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    op         = OP_APPEND;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            CMD_INSERT:
            begin
                if (pos_c >= cnt_c)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    op         = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_ERASE:
            begin
                if (pos_c >= cnt_c)
                    status = ST_RANGE;
                else
                begin
                    op         = OP_ERASE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_c >= cnt_c)
                    status = ST_RANGE;
                else
                    read_data = from_entry(rd_sel);
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        ctl.op   = accept ? op : OP_HOLD;
        ctl.pos  = pos_c;
        ctl.cnt  = cnt_c;
        ctl.data = to_entry(data_in);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t left_w;
            entry_t right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[g+1];
            end
            bai_cell u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .index   (CMP_W'(g)),
                .left    (left_w),
                .right   (right_w),
                .data    (cell_data[g]),
                .rd_term (cell_rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {6'b0, status, (count_next == '0),
                              (7)'(count_next), read_data};
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= accept ? count_next : count_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/bai_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bai_cell : one storage slot of the list
// Holds, loads the new word, or takes its left or right neighbour's entry.
// ----------------------------------------------------------------------------
module bai_cell (
    input  wire                        clk,
    input  wire  bai_pkg::cell_ctl_t   ctl,
    input  wire  [bai_pkg::CMP_W-1:0]  index,
    input  wire  bai_pkg::entry_t      left,
    input  wire  bai_pkg::entry_t      right,
    output bai_pkg::entry_t            data,
    output bai_pkg::entry_t            rd_term
);
    import bai_pkg::*;

    entry_t           data_reg;
    entry_t           data_next;
    logic [CMP_W-1:0] index_up;

    assign index_up = index + CMP_W'(1);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            OP_APPEND:
            begin
                if (index == ctl.cnt)
                    data_next = ctl.data;
            end
            OP_INSERT:
            begin
                if (index == ctl.pos)
                    data_next = ctl.data;
                else if (index > ctl.pos && index <= ctl.cnt)
                    data_next = left;
            end
            OP_ERASE:
            begin
                if (index >= ctl.pos && index_up < ctl.cnt)
                    data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_term = (index == ctl.pos) ? data_reg : '0;

endmodule
`default_nettype wire

@@ rtl/core/bai_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bai_checker : port-level checks for the bounded insert/erase list
// Result word consistency, a result after each accepted command, and output hold under back-pressure.
// ----------------------------------------------------------------------------
module bai_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        s_tvalid,
    input wire                        s_tready,
    input wire [bai_pkg::IN_W-1:0]    s_tdata,
    input wire                        m_tvalid,
    input wire                        m_tready,
    input wire [bai_pkg::OUT_W-1:0]   m_tdata
);
    import bai_pkg::*;

    logic [31:0] r_data;
    logic [6:0]  r_count;
    logic        r_empty;
    status_t     r_status;
    logic        in_seen;

    assign r_data   = m_tdata[31:0];
    assign r_count  = m_tdata[38:32];
    assign r_empty  = m_tdata[39];
    assign r_status = status_t'(m_tdata[41:40]);
    assign in_seen  = s_tvalid && s_tready && (s_tdata[47:41] == '0 || 1'b1);

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(r_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r_empty == (r_count == 7'd0)))
        else $error("empty flag disagrees with count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && r_status != ST_DONE) |-> (r_data == 32'd0))
        else $error("read data non-zero on failed command");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_seen |=> m_tvalid)
        else $error("no result after accepted command");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

endmodule

bind bounded_array_insert_erase bai_checker u_bai_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ verif/bounded_array_insert_erase_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_array_insert_erase_tb : self-checking bench for the shifting list
// Streams list commands into the block, keeps its own copy of the entries and
// count to work out every result word, and checks results field by field in
// order. Both sides idle at random; the receiver also holds off for a long
// stretch once, and the sender waits for an empty pipeline at times.
// ----------------------------------------------------------------------------
module bounded_array_insert_erase_tb;
    import bai_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_AT_WORD = 250;
    localparam int TAIL_WORDS   = 100;
    localparam int RANDOM_WORDS = 780;
    localparam int FLUSH_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]        command;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] data_in;
        bit                drain_first;
    } list_cmd_t;

    typedef struct {
        logic [WORD_W-1:0] read_data;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
        status_t           status;
    } list_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    entry_t       list_store [CAPACITY];
    int           list_len = 0;
    int           plan_len = 0;
    list_cmd_t    cmd_backlog [$];
    list_result_t pending_replies [$];

    int  total_words = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  cmd_seen [8];
    int  status_seen [4];
    bit  word_in_taken = 1'b0;
    bit  tail_phase;

    int  tx_gap_left = 0;
    int  tx_idle_pct = 20;
    int  rx_gap_left = 0;
    int  rx_idle_pct = 20;
    int  rx_hold_left = 0;
    bit  hold_done = 1'b0;

    assign tail_phase = (words_in + TAIL_WORDS >= total_words);

    bounded_array_insert_erase u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // next state of the list and the result word for one command
    function automatic list_result_t list_apply(input list_cmd_t c);
        list_result_t r;
        int           p;
        int           i;
        r.read_data = '0;
        r.status = ST_DONE;
        p = int'(c.position);
        case (c.command)
            CMD_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_store[list_len] = entry_t'(c.data_in);
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    list_len--;
            end
            CMD_INSERT:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_store[i] = list_store[i-1];
                    list_store[p] = entry_t'(c.data_in);
                    list_len++;
                end
            end
            CMD_ERASE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = p; i + 1 < list_len; i++)
                        list_store[i] = list_store[i+1];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_data = WORD_W'(signed'(list_store[p]));
            end
            default:
            begin
            end
        endcase
        r.entry_count = CNT_W'(list_len);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 15))
            0:       w = 32'h7FFF_FFFF;
            1:       w = 32'h8000_0000;
            2:       w = 32'h0000_0000;
            3:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // queue a command and track the count it will leave behind
    task automatic queue_cmd(input logic [2:0] cmd, input int pos,
                             input logic [WORD_W-1:0] data, input bit drain = 1'b0);
        list_cmd_t c;
        c.command = cmd;
        c.position = POS_W'(pos);
        c.data_in = data;
        c.drain_first = drain;
        cmd_backlog.push_back(c);
        case (cmd)
            CMD_APPEND:
                if (plan_len < CAPACITY)
                    plan_len++;
            CMD_REMOVE:
                if (plan_len > 0)
                    plan_len--;
            CMD_INSERT:
                if (pos < plan_len && plan_len < CAPACITY)
                    plan_len++;
            CMD_ERASE:
                if (pos < plan_len)
                    plan_len--;
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_position();
        int p;
        if (plan_len > 0 && $urandom_range(0, 99) < 85)
            p = $urandom_range(0, plan_len - 1);
        else
            p = $urandom_range(0, 63);
        return p;
    endfunction

    task automatic queue_random(input int grow_pct, input bit drain);
        logic [2:0] cmd;
        int         r;
        bit         grow;
        r = $urandom_range(0, 99);
        grow = ($urandom_range(0, 99) < grow_pct);
        if (r < 2)
            cmd = CMD_SPARE_LO + 3'($urandom_range(0, 2));
        else if (r < 20)
            cmd = CMD_READ;
        else if (grow)
            cmd = r[0] ? CMD_APPEND : CMD_INSERT;
        else
            cmd = r[0] ? CMD_REMOVE : CMD_ERASE;
        queue_cmd(cmd, pick_position(), random_word(), drain);
    endtask

    // stimulus
    initial
    begin
        int seg;
        int k;
        int seg_len;
        int mode;

        // empty list
        queue_cmd(CMD_REMOVE, 0, 32'h0);
        queue_cmd(CMD_READ, 0, 32'h0);
        queue_cmd(CMD_INSERT, 0, 32'h1111_1111);
        queue_cmd(CMD_ERASE, 0, 32'h0);
        queue_cmd(CMD_SPARE_LO, 63, 32'hFFFF_FFFF);
        // extremes of the data word
        queue_cmd(CMD_APPEND, 63, 32'h7FFF_FFFF);
        queue_cmd(CMD_APPEND, 0, 32'h8000_0000);
        queue_cmd(CMD_APPEND, 0, 32'h0000_0000);
        queue_cmd(CMD_APPEND, 0, 32'hFFFF_FFFF);
        // insert at front, middle and last index, then try the end position (out of range)
        queue_cmd(CMD_INSERT, 0, 32'h1234_5678);
        queue_cmd(CMD_INSERT, 2, 32'hA5A5_A5A5);
        queue_cmd(CMD_INSERT, 5, 32'h5A5A_5A5A);
        queue_cmd(CMD_INSERT, 7, 32'hDEAD_BEEF);
        queue_cmd(CMD_READ, 0, 32'h0);
        queue_cmd(CMD_READ, 3, 32'h0);
        queue_cmd(CMD_READ, 6, 32'h0);
        queue_cmd(CMD_READ, 7, 32'h0);
        queue_cmd(CMD_READ, 63, 32'h0);
        queue_cmd(CMD_ERASE, 0, 32'h0);
        queue_cmd(CMD_ERASE, 2, 32'h0);
        queue_cmd(CMD_ERASE, 4, 32'h0);
        queue_cmd(CMD_ERASE, 4, 32'h0);
        queue_cmd(CMD_REMOVE, 0, 32'h0);
        queue_cmd(CMD_SPARE_HI, 21, 32'h5555_AAAA);
        queue_cmd(CMD_READ, 2, 32'h0);

        seg = 0;
        while (cmd_backlog.size() < 25 + RANDOM_WORDS)
        begin
            mode = $urandom_range(0, 4);
            seg_len = $urandom_range(20, 90);
            if (mode == 3)
            begin
                // fill to capacity, then knock on the full list
                queue_random(100, seg % 4 == 3);
                while (plan_len < CAPACITY)
                begin
                    if ($urandom_range(0, 4) == 0)
                        queue_cmd(CMD_READ, pick_position(), random_word());
                    else
                        queue_cmd(CMD_APPEND, pick_position(), random_word());
                end
                for (k = 0; k < 6; k++)
                    queue_cmd($urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT,
                              $urandom_range(0, 63), random_word());
                queue_cmd(CMD_READ, CAPACITY - 1, 32'h0);
            end
            else if (mode == 4)
            begin
                // drain to empty, then shrink the empty list
                queue_random(0, seg % 4 == 3);
                while (plan_len > 0)
                    queue_cmd($urandom_range(0, 1) ? CMD_REMOVE : CMD_ERASE,
                              pick_position(), random_word());
                queue_cmd(CMD_REMOVE, 0, random_word());
                queue_cmd(CMD_ERASE, $urandom_range(0, 63), random_word());
                queue_cmd(CMD_READ, $urandom_range(0, 63), random_word());
            end
            else
            begin
                for (k = 0; k < seg_len; k++)
                    queue_random(mode == 0 ? 75 : (mode == 1 ? 25 : 50),
                                 k == 0 && seg % 4 == 3);
            end
            seg++;
        end
        total_words = cmd_backlog.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(cmd_backlog.size() == 0 && !s_tvalid && pending_replies.size() == 0))
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);

        $display("%0d commands: append %0d, remove %0d, insert %0d, erase %0d, read %0d, spare %0d",
                 words_in, cmd_seen[CMD_APPEND], cmd_seen[CMD_REMOVE], cmd_seen[CMD_INSERT],
                 cmd_seen[CMD_ERASE], cmd_seen[CMD_READ],
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
        $display("%0d results: done %0d, out of range %0d, full %0d, empty %0d",
                 words_out, status_seen[ST_DONE], status_seen[ST_RANGE],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("bounded_array_insert_erase_tb passed");
        else
            $display("bounded_array_insert_erase_tb failed");
        $finish;
    end

    // sender
    always @(negedge clk)
    begin
        list_cmd_t next_cmd;
        logic      offer;
        if (rst_n && !(s_tvalid && !word_in_taken))
        begin
            offer = 1'b0;
            if (tx_gap_left > 0)
                tx_gap_left--;
            else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain_first && pending_replies.size() != 0))
            begin
                next_cmd = cmd_backlog.pop_front();
                offer = 1'b1;
                s_tdata <= IN_W'({next_cmd.data_in, next_cmd.position, next_cmd.command});
                if (!tail_phase && rx_hold_left == 0 && $urandom_range(0, 99) < tx_idle_pct)
                    tx_gap_left = $urandom_range(1, 8);
                if ($urandom_range(0, 63) == 0)
                    tx_idle_pct = 15 * $urandom_range(0, 2);
            end
            s_tvalid <= offer;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_left > 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && words_in >= HOLD_AT_WORD)
            begin
                hold_done <= 1'b1;
                rx_hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!tail_phase && $urandom_range(0, 99) < rx_idle_pct)
                    rx_gap_left = $urandom_range(1, 8);
                if ($urandom_range(0, 63) == 0)
                    rx_idle_pct = 15 * $urandom_range(0, 2);
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        list_cmd_t    taken;
        list_result_t seen;
        list_result_t want;
        bit           word_out_taken;
        if (rst_n)
        begin
            word_in_taken = s_tvalid && s_tready;
            word_out_taken = m_tvalid && m_tready;

            if (word_out_taken)
            begin
                // [31:0] data, [38:32] count, [39] empty, [41:40] status
                seen.read_data = m_tdata[31:0];
                seen.entry_count = m_tdata[38:32];
                seen.is_empty = m_tdata[39];
                seen.status = status_t'(m_tdata[41:40]);
                words_out++;
                if (pending_replies.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result word %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    status_seen[want.status]++;
                    if (seen.read_data !== want.read_data
                        || seen.entry_count !== want.entry_count
                        || seen.is_empty !== want.is_empty
                        || seen.status !== want.status)
                    begin
                        if (mismatches < MAX_REPORTS)
                        begin
                            $write("result %0d: expected data %h count %0d empty %b status %s, ",
                                   words_out, want.read_data, want.entry_count,
                                   want.is_empty, want.status.name());
                            $display("got data %h count %0d empty %b status %0d",
                                     seen.read_data, seen.entry_count, seen.is_empty,
                                     m_tdata[41:40]);
                        end
                        mismatches++;
                    end
                end
            end

            if (word_in_taken)
            begin
                taken.command = s_tdata[2:0];
                taken.position = s_tdata[8:3];
                taken.data_in = s_tdata[40:9];
                taken.drain_first = 1'b0;
                pending_replies.push_back(list_apply(taken));
                cmd_seen[taken.command]++;
                words_in++;
            end

            if (word_in_taken || word_out_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("bounded_array_insert_erase_tb failed");
                $finish;
            end
        end
    end

endmodule
